// ===== sv/brgb_pkg.sv =====
// Shared types, constants and a helper function for the breathing RGB LED driver.
package brgb_pkg;

  // Brightness ceiling of the triangle and period of the shared PWM phase
  localparam int unsigned MaxLevel = 40;

  // Widths of levels, counters and configuration
  localparam int unsigned LvlW  = 6;
  localparam int unsigned RateW = 3;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned NumCh = 3;

  localparam logic [LvlW-1:0] LvlMax   = LvlW'(MaxLevel);
  localparam logic [LvlW-1:0] ElapsSat = {LvlW{1'b1}};

  // Configuration register indexes
  localparam logic [IdxW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [IdxW-1:0] CFG_RED    = 2'd1;
  localparam logic [IdxW-1:0] CFG_GREEN  = 2'd2;
  localparam logic [IdxW-1:0] CFG_BLUE   = 2'd3;

  // Rate codes
  localparam logic [RateW-1:0] RATE_50MS = 3'd0;
  localparam logic [RateW-1:0] RATE_45MS = 3'd1;
  localparam logic [RateW-1:0] RATE_40MS = 3'd2;
  localparam logic [RateW-1:0] RATE_35MS = 3'd3;
  localparam logic [RateW-1:0] RATE_30MS = 3'd4;

  // Per-request control handed to each channel
  typedef struct packed {
    logic step;    // request accepted this cycle
    logic tick;    // one millisecond passed
    logic enable;  // breathing running
    logic clear;   // enable written low: drop level now
  } brgb_ctl_t;

  // Step interval in ms for a rate code; unknown codes run at the fastest rate
  function automatic logic [LvlW-1:0] interval_of(input logic [RateW-1:0] code);
    logic [LvlW-1:0] ms;
    unique case (code)
      RATE_50MS: ms = 6'd50;
      RATE_45MS: ms = 6'd45;
      RATE_40MS: ms = 6'd40;
      RATE_35MS: ms = 6'd35;
      default:   ms = 6'd30;
    endcase
    return ms;
  endfunction

endpackage

// ===== sv/brgb_chan.sv =====
// One colour channel: elapsed-ms counter, triangle brightness and PWM compare.
module brgb_chan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  brgb_pkg::brgb_ctl_t    ctl,
  input  logic [brgb_pkg::RateW-1:0] rate,
  input  logic [brgb_pkg::LvlW-1:0]  phase_nxt,
  output logic                   lit
);
  import brgb_pkg::*;

  logic [LvlW-1:0] elaps_r, elaps_nxt;
  logic [LvlW-1:0] level_r, level_nxt;
  logic            rising_r, rising_nxt;
  logic [LvlW-1:0] elaps_inc;
  logic            rise_dir;
  logic            due;

  // saturating millisecond count
  assign elaps_inc = (ctl.tick && (elaps_r != ElapsSat)) ? elaps_r + 1'b1 : elaps_r;
  assign due       = (elaps_inc >= interval_of(rate));

  // direction flips at the ends of the triangle
  always_comb begin
    rise_dir = rising_r;
    if (level_r >= LvlMax) begin
      rise_dir = 1'b0;
    end else if (level_r == '0) begin
      rise_dir = 1'b1;
    end
  end

  // next state for this request
  always_comb begin
    elaps_nxt  = elaps_r;
    level_nxt  = level_r;
    rising_nxt = rising_r;
    if (ctl.clear) begin
      level_nxt = '0;
    end else if (ctl.step) begin
      elaps_nxt = elaps_inc;
      if (!ctl.enable) begin
        level_nxt = '0;
      end else if (due) begin
        elaps_nxt  = '0;
        rising_nxt = rise_dir;
        level_nxt  = rise_dir ? level_r + 1'b1 : level_r - 1'b1;
      end
    end
  end

  // lit while the new phase sits below the new level
  assign lit = ctl.enable && (phase_nxt < level_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elaps_r  <= '0;
      level_r  <= '0;
      rising_r <= 1'b1;
    end else begin
      elaps_r  <= elaps_nxt;
      level_r  <= level_nxt;
      rising_r <= rising_nxt;
    end
  end

endmodule

// ===== sv/brgb_out_buf.sv =====
// Result register with skid stage: takes a request while a result still waits.
module brgb_out_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [brgb_pkg::NumCh-1:0] push_data,
  output logic                     full,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [brgb_pkg::NumCh-1:0] out_data
);
  import brgb_pkg::*;

  logic             oval_r, oval_nxt;
  logic             sval_r, sval_nxt;
  logic [NumCh-1:0] odat_r, odat_nxt;
  logic [NumCh-1:0] sdat_r, sdat_nxt;

  assign full      = sval_r;
  assign out_valid = oval_r;
  assign out_data  = odat_r;

  // refill the output from skid first, else from the new request
  always_comb begin
    oval_nxt = oval_r;
    sval_nxt = sval_r;
    odat_nxt = odat_r;
    sdat_nxt = sdat_r;
    if (!oval_r || !out_stall) begin
      oval_nxt = sval_r || push;
      odat_nxt = sval_r ? sdat_r : push_data;
      sval_nxt = 1'b0;
    end else if (push) begin
      sval_nxt = 1'b1;
      sdat_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
      sval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      sval_r <= sval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odat_r <= odat_nxt;
    sdat_r <= sdat_nxt;
  end

endmodule

// ===== sv/breathing_rgb_led_pwm.sv =====
// Top level of the three-channel breathing LED driver with shared PWM phase.
//
//  port group  direction  handshake              payload
//  in_         request    in_valid / in_stall    in_ms_tick
//  out_        result     out_valid / out_stall  out_red_on, out_green_on, out_blue_on
//  cfg_        write      cfg_we                 cfg_index, cfg_wdata
//
// One request per clock while in_stall is low; each accepted result is registered.
// State updates in the accepting cycle; a result register plus one skid entry
// sets the stall: in_stall rises only once both hold unclaimed results.
// Synchronous active-low reset: disabled, rates at 30 ms, levels zero, rising.
module breathing_rgb_led_pwm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_ms_tick,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_red_on,
  output logic                         out_green_on,
  output logic                         out_blue_on,
  input  logic                         cfg_we,
  input  logic [brgb_pkg::IdxW-1:0]    cfg_index,
  input  logic [brgb_pkg::RateW-1:0]   cfg_wdata
);
  import brgb_pkg::*;

  logic             enable_r, enable_nxt;
  logic [RateW-1:0] rate_r [NumCh];
  logic [RateW-1:0] rate_nxt [NumCh];
  logic [LvlW-1:0]  phase_r, phase_nxt;
  logic [LvlW:0]    phase_inc;
  logic             accept;
  logic             full;
  brgb_ctl_t        ctl;
  logic [NumCh-1:0] lit;
  logic [NumCh-1:0] res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // configuration writes
  always_comb begin
    enable_nxt = enable_r;
    rate_nxt   = rate_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_nxt  = cfg_wdata[0];
        CFG_RED:    rate_nxt[0] = cfg_wdata;
        CFG_GREEN:  rate_nxt[1] = cfg_wdata;
        CFG_BLUE:   rate_nxt[2] = cfg_wdata;
        default:    enable_nxt  = enable_r;
      endcase
    end
  end

  assign ctl.step   = accept;
  assign ctl.tick   = in_ms_tick;
  assign ctl.enable = enable_r;
  assign ctl.clear  = cfg_we && (cfg_index == CFG_ENABLE) && !cfg_wdata[0];

  // shared PWM phase, wraps below the level ceiling
  assign phase_inc = {1'b0, phase_r} + 1'b1;
  always_comb begin
    phase_nxt = phase_r;
    if (accept && enable_r) begin
      phase_nxt = (phase_inc >= {1'b0, LvlMax}) ? '0 : phase_inc[LvlW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      phase_r  <= '0;
      for (int i = 0; i < NumCh; i++) begin
        rate_r[i] <= RATE_30MS;
      end
    end else begin
      enable_r <= enable_nxt;
      phase_r  <= phase_nxt;
      rate_r   <= rate_nxt;
    end
  end

  // colour channels
  for (genvar g = 0; g < NumCh; g++) begin : g_chan
    brgb_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rate      (rate_r[g]),
      .phase_nxt (phase_nxt),
      .lit       (lit[g])
    );
  end

  // result queue
  brgb_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (lit),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res)
  );

  assign out_red_on   = res[0];
  assign out_green_on = res[1];
  assign out_blue_on  = res[2];

endmodule
